/* sv/frc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the frame rate code search.
package frc_pkg;

    localparam int NUM_BASE  = 8;
    localparam int NUM_RATIO = 86;
    localparam int PW        = 50;
    localparam int HW        = PW / 2;
    localparam int XW        = 2 * PW;
    localparam int MUL_STEPS = 8;

    localparam logic [3:0] FAIL_CODE = 4'd5;

    typedef struct packed {
        logic [31:0] rate_num;
        logic [31:0] rate_den;
    } t_in;

    typedef struct packed {
        logic       supported;
        logic [3:0] rate_code;
        logic [1:0] ext_n;
        logic [4:0] ext_d;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_EXACT,
        ST_SEARCH,
        ST_MUL,
        ST_UPD,
        ST_FINAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       load_in;
        logic       prep;
        logic       shift;
        logic       mul;
        logic       upd;
        logic       set_exact;
        logic       set_fail;
        logic       set_final;
        logic       load_out;
        logic       sel;
        logic [2:0] j;
        logic [6:0] i;
        logic [2:0] k;
    } t_cmd;

    typedef struct packed {
        logic exact_match;
        logic reject_early;
        logic hit;
    } t_status;

    // Base rates counted per 1001 seconds.
    function automatic logic [15:0] base1001(input logic [2:0] j);
        logic [15:0] r;
        case (j)
            3'd0: r = 16'd24000;
            3'd1: r = 16'd24024;
            3'd2: r = 16'd25025;
            3'd3: r = 16'd30000;
            3'd4: r = 16'd30030;
            3'd5: r = 16'd50050;
            3'd6: r = 16'd60000;
            default: r = 16'd60060;
        endcase
        return r;
    endfunction

    // Ascending extension ratios, returned as {numerator, denominator}.
    function automatic logic [8:0] ratio_ab(input logic [6:0] i);
        logic [8:0] r;
        case (i)
            7'd0:  r = {3'd1, 6'd32}; 7'd1:  r = {3'd1, 6'd31}; 7'd2:  r = {3'd1, 6'd30};
            7'd3:  r = {3'd1, 6'd29}; 7'd4:  r = {3'd1, 6'd28}; 7'd5:  r = {3'd1, 6'd27};
            7'd6:  r = {3'd1, 6'd26}; 7'd7:  r = {3'd1, 6'd25}; 7'd8:  r = {3'd1, 6'd24};
            7'd9:  r = {3'd1, 6'd23}; 7'd10: r = {3'd1, 6'd22}; 7'd11: r = {3'd1, 6'd21};
            7'd12: r = {3'd1, 6'd20}; 7'd13: r = {3'd1, 6'd19}; 7'd14: r = {3'd1, 6'd18};
            7'd15: r = {3'd1, 6'd17}; 7'd16: r = {3'd1, 6'd16}; 7'd17: r = {3'd2, 6'd31};
            7'd18: r = {3'd1, 6'd15}; 7'd19: r = {3'd2, 6'd29}; 7'd20: r = {3'd1, 6'd14};
            7'd21: r = {3'd2, 6'd27}; 7'd22: r = {3'd1, 6'd13}; 7'd23: r = {3'd2, 6'd25};
            7'd24: r = {3'd1, 6'd12}; 7'd25: r = {3'd2, 6'd23}; 7'd26: r = {3'd1, 6'd11};
            7'd27: r = {3'd3, 6'd32}; 7'd28: r = {3'd2, 6'd21}; 7'd29: r = {3'd3, 6'd31};
            7'd30: r = {3'd1, 6'd10}; 7'd31: r = {3'd3, 6'd29}; 7'd32: r = {3'd2, 6'd19};
            7'd33: r = {3'd3, 6'd28}; 7'd34: r = {3'd1, 6'd9};  7'd35: r = {3'd3, 6'd26};
            7'd36: r = {3'd2, 6'd17}; 7'd37: r = {3'd3, 6'd25}; 7'd38: r = {3'd1, 6'd8};
            7'd39: r = {3'd4, 6'd31}; 7'd40: r = {3'd3, 6'd23}; 7'd41: r = {3'd2, 6'd15};
            7'd42: r = {3'd3, 6'd22}; 7'd43: r = {3'd4, 6'd29}; 7'd44: r = {3'd1, 6'd7};
            7'd45: r = {3'd4, 6'd27}; 7'd46: r = {3'd3, 6'd20}; 7'd47: r = {3'd2, 6'd13};
            7'd48: r = {3'd3, 6'd19}; 7'd49: r = {3'd4, 6'd25}; 7'd50: r = {3'd1, 6'd6};
            7'd51: r = {3'd4, 6'd23}; 7'd52: r = {3'd3, 6'd17}; 7'd53: r = {3'd2, 6'd11};
            7'd54: r = {3'd3, 6'd16}; 7'd55: r = {3'd4, 6'd21}; 7'd56: r = {3'd1, 6'd5};
            7'd57: r = {3'd4, 6'd19}; 7'd58: r = {3'd3, 6'd14}; 7'd59: r = {3'd2, 6'd9};
            7'd60: r = {3'd3, 6'd13}; 7'd61: r = {3'd4, 6'd17}; 7'd62: r = {3'd1, 6'd4};
            7'd63: r = {3'd4, 6'd15}; 7'd64: r = {3'd3, 6'd11}; 7'd65: r = {3'd2, 6'd7};
            7'd66: r = {3'd3, 6'd10}; 7'd67: r = {3'd4, 6'd13}; 7'd68: r = {3'd1, 6'd3};
            7'd69: r = {3'd4, 6'd11}; 7'd70: r = {3'd3, 6'd8};  7'd71: r = {3'd2, 6'd5};
            7'd72: r = {3'd3, 6'd7};  7'd73: r = {3'd4, 6'd9};  7'd74: r = {3'd1, 6'd2};
            7'd75: r = {3'd4, 6'd7};  7'd76: r = {3'd3, 6'd5};  7'd77: r = {3'd2, 6'd3};
            7'd78: r = {3'd3, 6'd4};  7'd79: r = {3'd4, 6'd5};  7'd80: r = {3'd1, 6'd1};
            7'd81: r = {3'd4, 6'd3};  7'd82: r = {3'd3, 6'd2};  7'd83: r = {3'd2, 6'd1};
            7'd84: r = {3'd3, 6'd1};  7'd85: r = {3'd4, 6'd1};
            default: r = {3'd1, 6'd1};
        endcase
        return r;
    endfunction

endpackage

/* sv/frame_rate_code_search.sv */
`timescale 1ns / 1ps
// Top level of the frame rate to MPEG-2 rate code search.
// One beat in gives one beat out. A rate that matches a base rate exactly gives its
// result from the exact-match pass; a rejected low or zero rate ends after that pass;
// a full search is set by the ratio test done one ratio per cycle and by one 25x25
// partial-product multiplier, whose partial products (ST_MUL) are followed by one
// compare (ST_UPD) per scored candidate (up to 16 candidates). The finished result sits
// in an output register, so the next beat is accepted while it waits to be taken.
module frame_rate_code_search import frc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_cmd    w_cmd;
    t_status w_status;

    frc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    frc_dp u_dp (
        .i_clk    (i_clk),
        .i_data   (i_data),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_data   (o_data)
    );

endmodule

/* sv/frc_dp.sv */
`timescale 1ns / 1ps
// Datapath: operand registers, ratio tests, partial-product multiplier and best-score tracking.
module frc_dp import frc_pkg::*; (
    input  logic    i_clk,
    input  t_in     i_data,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output t_out    o_data
);

    logic [31:0]   r_n;
    logic [31:0]   r_d;
    logic [41:0]   r_nk;
    logic [42:0]   r_s;
    logic          r_rej;
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_q;
    logic [PW-1:0] r_pp;
    logic [PW-1:0] r_pq;
    logic [XW-1:0] r_x;
    logic [XW-1:0] r_y;
    logic [PW-1:0] r_bn;
    logic [PW-1:0] r_bd;
    logic [6:0]    r_besti;
    logic [2:0]    r_bestj;
    t_out          r_res;
    t_out          r_out;

    logic [15:0]   w_base;
    logic [8:0]    w_rt;
    logic [8:0]    w_brt;
    logic [17:0]   w_ra;
    logic [PW-1:0] w_p;
    logic [PW-1:0] w_q;
    logic [PW-1:0] w_lo;
    logic [PW-1:0] w_cn;
    logic [PW-1:0] w_cd;
    logic [PW-1:0] w_opa;
    logic [PW-1:0] w_opb;
    logic [HW-1:0] w_pa;
    logic [HW-1:0] w_pb;
    logic [PW-1:0] w_pprod;
    logic [XW-1:0] w_ppsh;
    logic [XW-1:0] w_acc;
    logic [XW-1:0] w_sum;
    logic          w_rej_final;
    logic          w_low;

    assign w_base = base1001(i_cmd.j);
    assign w_rt   = ratio_ab(i_cmd.i);
    assign w_brt  = ratio_ab(r_besti);
    assign w_ra   = 18'(w_base) * 18'(w_rt[8:6]);
    assign w_p    = PW'(w_ra) * PW'(r_d);
    assign w_q    = PW'(r_nk) * PW'(w_rt[5:0]);
    assign w_lo   = PW'(r_d) * PW'({w_base, 1'b0});
    assign w_low  = (51'(r_n) * 51'd320320) < (51'(r_d) * 51'd168000);

    assign o_status.exact_match  = (w_lo <= PW'(r_s)) && (PW'(r_s) < (w_lo + PW'({r_d, 1'b0})));
    assign o_status.reject_early = r_rej;
    assign o_status.hit          = (i_cmd.i == 7'(NUM_RATIO)) || (w_p > w_q);

    assign w_cn  = i_cmd.sel ? r_p : r_pq;
    assign w_cd  = i_cmd.sel ? r_q : r_pp;
    assign w_opa = i_cmd.k[2] ? r_bn : w_cn;
    assign w_opb = i_cmd.k[2] ? w_cd : r_bd;
    assign w_pa  = i_cmd.k[0] ? w_opa[PW-1:HW] : w_opa[HW-1:0];
    assign w_pb  = i_cmd.k[1] ? w_opb[PW-1:HW] : w_opb[HW-1:0];
    assign w_pprod = PW'(w_pa) * PW'(w_pb);

    always_comb begin
        case (i_cmd.k[1:0])
            2'b00:   w_ppsh = XW'(w_pprod);
            2'b11:   w_ppsh = XW'(w_pprod) << (2 * HW);
            default: w_ppsh = XW'(w_pprod) << HW;
        endcase
    end

    assign w_acc = (i_cmd.k[1:0] == 2'b00) ? '0 : (i_cmd.k[2] ? r_y : r_x);
    assign w_sum = w_acc + w_ppsh;

    assign w_rej_final = (58'(r_bd) * 58'd201) < (58'(r_bn) * 58'd200);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_n <= i_data.rate_num;
            r_d <= i_data.rate_den;
        end
        if (i_cmd.prep) begin
            r_nk    <= 42'(r_n) * 42'd1001;
            r_s     <= 43'(r_n) * 43'd2002 + 43'(r_d);
            r_rej   <= (r_n == '0) || (r_d == '0) || w_low;
            r_bn    <= PW'(3);
            r_bd    <= PW'(2);
            r_besti <= '0;
            r_bestj <= '0;
        end
        if (i_cmd.shift) begin
            r_pp <= r_p;
            r_pq <= r_q;
            r_p  <= w_p;
            r_q  <= w_q;
        end
        if (i_cmd.mul) begin
            if (i_cmd.k[2]) begin
                r_y <= w_sum;
            end else begin
                r_x <= w_sum;
            end
        end
        if (i_cmd.upd && (r_x < r_y)) begin
            r_bn    <= w_cn;
            r_bd    <= w_cd;
            r_besti <= i_cmd.sel ? i_cmd.i : i_cmd.i - 7'd1;
            r_bestj <= i_cmd.j;
        end
        if (i_cmd.set_exact) begin
            r_res.supported <= 1'b1;
            r_res.rate_code <= 4'(i_cmd.j) + 4'd1;
            r_res.ext_n     <= '0;
            r_res.ext_d     <= '0;
        end
        if (i_cmd.set_fail || (i_cmd.set_final && w_rej_final)) begin
            r_res.supported <= 1'b0;
            r_res.rate_code <= FAIL_CODE;
            r_res.ext_n     <= '0;
            r_res.ext_d     <= '0;
        end else if (i_cmd.set_final) begin
            r_res.supported <= 1'b1;
            r_res.rate_code <= 4'(r_bestj) + 4'd1;
            r_res.ext_n     <= 2'(w_brt[8:6] - 3'd1);
            r_res.ext_d     <= 5'(w_brt[5:0] - 6'd1);
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_data = r_out;

endmodule

/* sv/frc_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences exact match, ratio search, score compares and the output beat.
module frc_ctrl import frc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_j, n_j;
    logic [6:0] r_i, n_i;
    logic [2:0] r_k, n_k;
    logic       r_sel, n_sel;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_valid    = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_i         = r_i;
        n_k         = r_k;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_j     = '0;
                n_state = ST_EXACT;
            end
            ST_EXACT: begin
                if (i_status.exact_match) begin
                    n_state = ST_DONE;
                end else if (r_j == 3'(NUM_BASE - 1)) begin
                    n_j     = '0;
                    n_i     = '0;
                    n_state = i_status.reject_early ? ST_DONE : ST_SEARCH;
                end else begin
                    n_j = r_j + 3'd1;
                end
            end
            ST_SEARCH: begin
                if (i_status.hit) begin
                    n_k     = '0;
                    n_sel   = (r_i == '0);
                    n_state = ST_MUL;
                end else begin
                    n_i = r_i + 7'd1;
                end
            end
            ST_MUL: begin
                n_k = r_k + 3'd1;
                if (r_k == 3'(MUL_STEPS - 1)) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (!r_sel && (r_i != 7'(NUM_RATIO))) begin
                    n_sel   = 1'b1;
                    n_k     = '0;
                    n_state = ST_MUL;
                end else if (r_j == 3'(NUM_BASE - 1)) begin
                    n_state = ST_FINAL;
                end else begin
                    n_j     = r_j + 3'd1;
                    n_i     = '0;
                    n_state = ST_SEARCH;
                end
            end
            ST_FINAL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.j   = r_j;
        o_cmd.i   = r_i;
        o_cmd.k   = r_k;
        o_cmd.sel = r_sel;
        o_stall   = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.load_in = i_valid;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
            end
            ST_EXACT: begin
                o_cmd.set_exact = i_status.exact_match;
                o_cmd.set_fail  = !i_status.exact_match && (r_j == 3'(NUM_BASE - 1))
                                  && i_status.reject_early;
            end
            ST_SEARCH: begin
                o_cmd.shift = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
            end
            ST_FINAL: begin
                o_cmd.set_final = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_j         <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_i         <= n_i;
            r_k         <= n_k;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_stall))
        else $error("Result loaded over a beat that is still waiting.");

    a_mul_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_k == 3'(MUL_STEPS - 1)) |=> (r_state == ST_UPD))
        else $error("Score compare did not follow the last partial product.");

    a_lower_needs_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && !r_sel) |-> (r_i != '0))
        else $error("Lower neighbor scored at the first ratio.");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> (r_state == ST_PREP && o_stall))
        else $error("Accepted beat did not start preparation.");

endmodule

/* sim/frame_rate_code_search_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the frame rate to MPEG-2 code search block.
module frame_rate_code_search_tb;
    import frc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    t_out code_q[$];
    int   errors;
    int   idle_send;
    int   idle_recv;
    int   quiet_cycles;
    bit   timed_out;

    localparam int WATCHDOG = 20000;

    frame_rate_code_search dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] base_rate(input int j);
        logic [15:0] r;
        case (j)
            0: r = 16'd24000;
            1: r = 16'd24024;
            2: r = 16'd25025;
            3: r = 16'd30000;
            4: r = 16'd30030;
            5: r = 16'd50050;
            6: r = 16'd60000;
            default: r = 16'd60060;
        endcase
        return r;
    endfunction

    // Ascending extension ratios a/b for entries 0 to 85; index 86 acts as the end of the table.
    function automatic void ext_ratio(input int i, output int a, output int b);
        int na[86] = '{1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,1,2,1,2,1,2,1,2,1,2,1,3,2,3,1,3,
                       2,3,1,3,2,3,1,4,3,2,3,4,1,4,3,2,3,4,1,4,3,2,3,4,1,4,3,2,3,4,
                       1,4,3,2,3,4,1,4,3,2,3,4,1,4,3,2,3,4,1,4,3,2,3,4};
        int nb[86] = '{32,31,30,29,28,27,26,25,24,23,22,21,20,19,18,17,16,31,15,29,14,27,
                       13,25,12,23,11,32,21,31,10,29,19,28,9,26,17,25,8,31,23,15,22,29,7,
                       27,20,13,19,25,6,23,17,11,16,21,5,19,14,9,13,17,4,15,11,7,10,13,3,
                       11,8,5,7,9,2,7,5,3,4,5,1,3,2,1,1,1};
        a = na[i];
        b = nb[i];
    endfunction

    function automatic t_out predict_code(input logic [31:0] num, input logic [31:0] den);
        t_out res;
        logic [127:0] n, d, fr, bn, bd, cn, cd, r;
        int besti, bestj, a, b, pa, pb;
        bit hit;
        res = '{supported: 1'b0, rate_code: FAIL_CODE, ext_n: 2'd0, ext_d: 5'd0};
        if (num == 0 || den == 0) return res;
        n = num;
        d = den;
        fr = (2 * 1001 * n + d) / (2 * d);
        for (int j = 0; j < 8; j++) begin
            if (fr == base_rate(j)) begin
                res.supported = 1'b1;
                res.rate_code = 4'(j + 1);
                return res;
            end
        end
        if (n * 320320 < d * 168000) return res;
        bn = 3; bd = 2; besti = 0; bestj = 0;
        for (int j = 0; j < 8; j++) begin
            r = base_rate(j);
            for (int i = 0; i <= 86; i++) begin
                hit = 1'b1;
                if (i < 86) begin
                    ext_ratio(i, a, b);
                    hit = r * a * d > 1001 * n * b;
                end
                if (hit) begin
                    if (i > 0) begin
                        ext_ratio(i - 1, pa, pb);
                        cn = 1001 * n * pb;
                        cd = r * pa * d;
                        if (cn * bd < bn * cd) begin
                            besti = i - 1; bestj = j; bn = cn; bd = cd;
                        end
                    end
                    if (i < 86) begin
                        cn = r * a * d;
                        cd = 1001 * n * b;
                        if (cn * bd < bn * cd) begin
                            besti = i; bestj = j; bn = cn; bd = cd;
                        end
                    end
                    break;
                end
            end
        end
        if (201 * bd < bn * 200) return res;
        ext_ratio(besti, a, b);
        res.supported = 1'b1;
        res.rate_code = 4'(bestj + 1);
        res.ext_n = 2'(a - 1);
        res.ext_d = 5'(b - 1);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task automatic send_rate(input logic [31:0] num, input logic [31:0] den);
        while ($urandom_range(99) < idle_send) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{rate_num: num, rate_den: den};
        code_q.push_back(predict_code(num, den));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < idle_recv);
            if (o_valid && !i_stall) begin
                if (code_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    t_out e;
                    e = code_q.pop_front();
                    if (o_data.supported !== e.supported)
                        report_mismatch($sformatf("supported %0b want %0b",
                                                  o_data.supported, e.supported));
                    if (o_data.rate_code !== e.rate_code)
                        report_mismatch($sformatf("code %0d want %0d",
                                                  o_data.rate_code, e.rate_code));
                    if (o_data.ext_n !== e.ext_n)
                        report_mismatch($sformatf("ext_n %0d want %0d", o_data.ext_n, e.ext_n));
                    if (o_data.ext_d !== e.ext_d)
                        report_mismatch($sformatf("ext_d %0d want %0d", o_data.ext_d, e.ext_d));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic drain;
        i_valid <= 1'b0;
        while (code_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic test_directed;
        send_rate(0, 1);
        send_rate(1, 0);
        send_rate(0, 0);
        send_rate(32'hffffffff, 32'hffffffff);
        send_rate(32'hffffffff, 1);
        send_rate(1, 32'hffffffff);
        send_rate(24000, 1001);
        send_rate(24, 1);
        send_rate(25, 1);
        send_rate(30000, 1001);
        send_rate(30, 1);
        send_rate(50, 1);
        send_rate(60000, 1001);
        send_rate(60, 1);
        send_rate(240001, 10000);
        send_rate(15, 1);
        send_rate(120, 1);
        send_rate(240, 1);
        send_rate(1, 2);
        send_rate(168000, 320320);
        send_rate(167999, 320320);
        send_rate(241, 1);
        send_rate(36, 1);
        send_rate(32'haaaaaaaa, 32'h55555555);
        send_rate(32'h55555555, 32'haaaaaaaa);
    endtask

    task automatic test_random(input int count);
        logic [31:0] num, den;
        int kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                den = $urandom_range(1, 5000);
                num = den * $urandom_range(1, 24000) / 100;
            end else if (kind < 8) begin
                den = $urandom_range(1, 1001);
                num = den * base_rate($urandom_range(7)) / 1001 + $urandom_range(1);
            end else begin
                num = $urandom;
                den = $urandom;
            end
            send_rate(num, den);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int count);
        idle_send = send_pct;
        idle_recv = recv_pct;
        test_random(count);
        drain();
    endtask

    initial begin
        errors = 0;
        timed_out = 1'b0;
        idle_send = 0;
        idle_recv = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain();
        run_phase(0, 0, 150);
        run_phase(77, 0, 140);
        run_phase(0, 77, 140);
        run_phase(7, 7, 125);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* files.f */
sv/frc_pkg.sv
sv/frc_dp.sv
sv/frc_ctrl.sv
sv/frame_rate_code_search.sv
sim/frame_rate_code_search_tb.sv
